[design/sil_pkg.sv]
// Package for the sorted insert list: field widths, opcode and status codes,
// controller state type and the default capacity. No dependencies.
package sil_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LIST   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LIST   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

endpackage

[design/sorted_insert_list_core.sv]
// Sorted insert list top level: entry memory, search/shift/list controller
// and output register. Depends on sil_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------
//   in      | in_valid / in_stall   | opcode, value
//   out     | out_valid / out_stall | value_res, index, status, last
//
// One item at a time; in_stall is high while an item is in work.
// Append, insert into a full or an empty list, and listing an empty list go
// straight to the finish state. Sorted insert makes one read pass up to the
// slot and, when the value lands before an existing entry, one pass back down
// to shift. Listing reads the entries in order. An unused opcode gives no result.
// A result held by out_stall delays the next result.
// Synchronous reset clears count, so the memory needs no clearing pass.
// The output register lets a new item be taken while a result waits.
module sorted_insert_list_core #(
  parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sil_pkg::OPCODE_W-1:0]        opcode,
  input  logic signed [sil_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sil_pkg::DATA_W-1:0]   value_res,
  output logic [sil_pkg::INDEX_W-1:0]         index,
  output logic [sil_pkg::STATUS_W-1:0]        status,
  output logic                                last
);
  import sil_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Entry memory and its registered read data
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            scan;      // next address to read
  logic [CW-1:0]            chk;       // address of the data in rd_data
  logic                     chk_vld;
  logic                     iss;       // shift reads still to issue
  logic [CW-1:0]            pos;
  logic signed [DATA_W-1:0] v_reg;
  logic [STATUS_W-1:0]      st;

  logic                     in_acc;
  logic                     out_free;
  logic                     post;
  logic                     hit;
  logic                     re;
  logic [AW-1:0]            ra;
  logic                     we;
  logic [AW-1:0]            wa;
  logic signed [DATA_W-1:0] wd;
  logic [CW-1:0]            last_addr;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_addr = count - 1'b1;

  // A new result enters the output register this cycle
  assign post = out_free && ((state == S_LIST && chk_vld) || state == S_FINISH);

  // Slot test: entry 0 wins only when strictly above, later ones when not smaller
  assign hit = (chk == '0) ? (v_reg < rd_data) : !(rd_data < v_reg);

  // Drive memory read and write ports from the controller state
  always_comb begin
    re = 1'b0;
    ra = scan[AW-1:0];
    we = 1'b0;
    wa = pos[AW-1:0];
    wd = rd_data;
    case (state)
      S_SEARCH: begin
        re = (scan < count);
      end
      S_SHIFT: begin
        re = iss;
        we = chk_vld;
        wa = AW'(chk + 1'b1);
      end
      S_LIST: begin
        re = !chk_vld || (out_free && (chk != last_addr));
        ra = chk_vld ? AW'(chk + 1'b1) : '0;
      end
      S_FINISH: begin
        we = out_free && (st == ST_OK);
        wd = v_reg;
      end
      default: begin
      end
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  // Controller and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
      iss       <= 1'b0;
    end else begin
      // drop the held result once transferred, unless a new one replaces it
      if (out_valid && !out_stall && !post) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (opcode)
              OP_APPEND, OP_INSERT: begin
                v_reg <= value;
                if (count == CW'(CAPACITY)) begin
                  st    <= ST_FULL;
                  pos   <= '0;
                  state <= S_FINISH;
                end else if (opcode == OP_APPEND || count == '0) begin
                  st    <= ST_OK;
                  pos   <= count;
                  state <= S_FINISH;
                end else begin
                  st      <= ST_OK;
                  scan    <= '0;
                  chk_vld <= 1'b0;
                  state   <= S_SEARCH;
                end
              end
              OP_LIST: begin
                if (count == '0) begin
                  st    <= ST_EMPTY;
                  pos   <= '0;
                  v_reg <= '0;
                  state <= S_FINISH;
                end else begin
                  chk_vld <= 1'b0;
                  state   <= S_LIST;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          // scan entries in order, one compare per cycle
          if (chk_vld && hit) begin
            pos     <= chk;
            scan    <= last_addr;
            chk_vld <= 1'b0;
            iss     <= 1'b1;
            state   <= S_SHIFT;
          end else if (chk_vld && chk == last_addr) begin
            pos   <= count;
            state <= S_FINISH;
          end else if (scan < count) begin
            chk     <= scan;
            chk_vld <= 1'b1;
            scan    <= scan + 1'b1;
          end else begin
            chk_vld <= 1'b0;
          end
        end
        S_SHIFT: begin
          // move entries pos..count-1 up one place, top first
          chk_vld <= iss;
          if (iss) begin
            chk <= scan;
            if (scan == pos) begin
              iss <= 1'b0;
            end else begin
              scan <= scan - 1'b1;
            end
          end
          if (chk_vld && chk == pos) begin
            state <= S_FINISH;
          end
        end
        S_LIST: begin
          // advance one entry per transfer
          if (!chk_vld) begin
            chk_vld <= 1'b1;
            chk     <= '0;
          end else if (out_free) begin
            out_valid <= 1'b1;
            value_res <= rd_data;
            index     <= INDEX_W'(chk);
            status    <= ST_OK;
            last      <= (chk == last_addr);
            if (chk == last_addr) begin
              chk_vld <= 1'b0;
              state   <= S_IDLE;
            end else begin
              chk <= chk + 1'b1;
            end
          end
        end
        S_FINISH: begin
          // store the value when the status is OK and post the single status result
          if (out_free) begin
            out_valid <= 1'b1;
            value_res <= v_reg;
            index     <= INDEX_W'(pos);
            status    <= st;
            last      <= 1'b1;
            if (st == ST_OK) begin
              count <= count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sim/tb_sorted_insert_list_core.sv]
// Testbench for sorted_insert_list_core: queued stimulus, clocked driver and
// monitor, and a shadow list that predicts every result.
// Depends on sil_pkg and the sorted_insert_list_core RTL.
module tb_sorted_insert_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sil_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 455;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PRESSURE_AT  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  // Opcode the block ignores
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [OPCODE_W-1:0]      op;
    logic signed [DATA_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic [INDEX_W-1:0]       idx;
    logic [STATUS_W-1:0]      st;
    logic                     lst;
  } list_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode = OP_APPEND;
  logic signed [DATA_W-1:0]   value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DATA_W-1:0]   value_res;
  logic [INDEX_W-1:0]         index;
  logic [STATUS_W-1:0]        status;
  logic                       last;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];

  // Shadow copy of the list
  logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
  int                       shadow_count = 0;

  int items_taken   = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;
  int burst_left    = 0;
  int errors        = 0;
  int results_seen  = 0;
  int full_drops    = 0;
  int empty_lists   = 0;
  int listings      = 0;
  int cycles        = 0;

  sorted_insert_list_core #(.CAPACITY(LIST_DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_res (value_res),
    .index     (index),
    .status    (status),
    .last      (last)
  );

  always #1 clk = ~clk;

  task automatic note_failure(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  task automatic expect_result(input logic signed [DATA_W-1:0] v, input int pos,
                               input logic [STATUS_W-1:0] st, input logic lst);
    list_result_t r;
    r.val = v;
    r.idx = pos[INDEX_W-1:0];
    r.st  = st;
    r.lst = lst;
    expected_results.push_back(r);
  endtask

  // Update the shadow list with one accepted item and queue its results
  task automatic apply_to_list(input logic [OPCODE_W-1:0] op,
                               input logic signed [DATA_W-1:0] v);
    int pos;
    if (op == OP_APPEND || op == OP_INSERT) begin
      if (shadow_count >= LIST_DEPTH) begin
        full_drops++;
        expect_result(v, 0, ST_FULL, 1'b1);
      end else begin
        if (op == OP_APPEND) begin
          pos = shadow_count;
        end else if (shadow_count == 0 || v < shadow_entries[0]) begin
          pos = 0;
        end else begin
          // equal to the head does not go in front of it
          pos = 1;
          while (pos < shadow_count && shadow_entries[pos] < v) pos++;
        end
        for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos] = v;
        shadow_count++;
        expect_result(v, pos, ST_OK, 1'b1);
      end
    end else if (op == OP_LIST) begin
      listings++;
      if (shadow_count == 0) begin
        empty_lists++;
        expect_result('0, 0, ST_EMPTY, 1'b1);
      end else begin
        for (int i = 0; i < shadow_count; i++)
          expect_result(shadow_entries[i], i, ST_OK, (i + 1 == shadow_count));
      end
    end
  endtask

  function automatic void queue_cmd(input logic [OPCODE_W-1:0] op,
                                    input logic signed [DATA_W-1:0] v);
    list_cmd_t c;
    c.op  = op;
    c.val = v;
    pending_cmds.push_back(c);
  endfunction

  // Mix of extremes, small values that collide, and full-range patterns
  function automatic logic signed [DATA_W-1:0] pick_value();
    int t;
    case ($urandom_range(7))
      0: pick_value = VAL_MIN;
      1: pick_value = VAL_MAX;
      2, 3: begin
        t = $urandom_range(6);
        pick_value = t - 3;
      end
      default: pick_value = $urandom();
    endcase
  endfunction

  // Sender gap: bursts with none, mostly short, a few long
  function automatic int next_gap();
    int r;
    if (hold_left > 0) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      burst_left = $urandom_range(40, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  // Driver: hold payload until transfer, then idle for the chosen gap
  always @(posedge clk) begin
    int        gap;
    logic      offer;
    list_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
      opcode   <= OP_APPEND;
      value    <= '0;
      gap       = 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        apply_to_list(opcode, value);
        items_taken <= items_taken + 1;
        offer = 1'b0;
        gap   = next_gap();
      end else if (!in_valid && gap > 0) begin
        gap--;
      end
      if (!offer && gap == 0 && pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        opcode <= c.op;
        value  <= c.val;
        offer   = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // Receiver stall: random segments, plus one long hold-off to back up the input
  always @(posedge clk) begin
    int seg_left;
    bit seg_stall;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      seg_left   = 0;
      seg_stall  = 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && items_taken >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (seg_left == 0) begin
        case ($urandom_range(9))
          0, 1: begin
            seg_stall = 1'b1;
            seg_left  = $urandom_range(3, 1);
          end
          2: begin
            seg_stall = 1'b1;
            seg_left  = $urandom_range(24, 8);
          end
          3: begin
            seg_stall = 1'b0;
            seg_left  = $urandom_range(80, 40);
          end
          default: begin
            seg_stall = 1'b0;
            seg_left  = $urandom_range(12, 1);
          end
        endcase
      end
      seg_left--;
      out_stall <= seg_stall;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    list_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result value_res=%0d index=%0d status=%0d last=%0b",
                               value_res, index, status, last));
      end else begin
        e = expected_results.pop_front();
        if (value_res !== e.val || index !== e.idx || status !== e.st || last !== e.lst)
          note_failure($sformatf({"result %0d: expected value_res=%0d index=%0d status=%0d ",
                                  "last=%0b, got value_res=%0d index=%0d status=%0d last=%0b"},
                                 results_seen, e.val, e.idx, e.st, e.lst,
                                 value_res, index, status, last));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("sorted_insert_list_core: mismatch");
      $finish;
    end
  end

  initial begin
    int counted;
    int r;

    // Directed: empty list, head and tail cases, equal-to-head, extremes
    queue_cmd(OP_LIST,   32'sd0);
    queue_cmd(OP_UNUSED, -32'sd1);
    queue_cmd(OP_INSERT, 32'sd100);
    queue_cmd(OP_INSERT, 32'sd100);
    queue_cmd(OP_INSERT, 32'sd50);
    queue_cmd(OP_APPEND, VAL_MIN);
    queue_cmd(OP_INSERT, VAL_MAX);
    queue_cmd(OP_INSERT, VAL_MIN);
    queue_cmd(OP_LIST,   -32'sd1);
    queue_cmd(OP_UNUSED, $urandom());
    queue_cmd(OP_INSERT, 32'sd100);
    queue_cmd(OP_APPEND, 32'sd0);
    queue_cmd(OP_INSERT, -32'sd1);
    queue_cmd(OP_LIST,   $urandom());
    // fill the remaining slots
    for (int i = 0; i < 7; i++)
      queue_cmd((i % 2 == 0) ? OP_INSERT : OP_APPEND, pick_value());
    // full list: both writes dropped, full listing, ignored opcode
    queue_cmd(OP_INSERT, VAL_MAX);
    queue_cmd(OP_APPEND, VAL_MIN);
    queue_cmd(OP_LIST,   32'sd0);
    queue_cmd(OP_UNUSED, 32'sd0);

    // Random mix, ignored opcodes included
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 30)      queue_cmd(OP_INSERT, pick_value());
      else if (r < 55) queue_cmd(OP_APPEND, pick_value());
      else if (r < 90) queue_cmd(OP_LIST,   $urandom());
      else             queue_cmd(OP_UNUSED, $urandom());
      counted++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("covered %0d input transfers and %0d result transfers in %0d cycles",
             items_taken, results_seen, cycles);
    $display("listings %0d (empty %0d), dropped on full %0d, failures %0d",
             listings, empty_lists, full_drops, errors);
    if (errors == 0)
      $display("sorted_insert_list_core: match");
    else
      $display("sorted_insert_list_core: mismatch");
    $finish;
  end

endmodule
